/* rtl/assert_macros.svh */
// Assertion helpers shared by the framer modules.
// Both forms take a label, the clock, the active-low reset, the property and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* rtl/evof_pkg.sv */
`timescale 1ns / 1ps

package evof_pkg;

	// Field and register widths
	localparam int TS_W    = 48;
	localparam int LEN_W   = 31;
	localparam int DIM_W   = 6;
	localparam int PIX_W   = 5;
	localparam int ROW_W   = 32;
	localparam int IDX_W   = 5;
	localparam int CFG_IDX_W = 2;

	// Frame storage never exceeds this many rows or columns
	localparam int HW_LIMIT = 32;

	// Parameter defaults
	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 32;

	// Register reset values
	localparam logic [DIM_W-1:0] RST_ROWS = DIM_W'(32);
	localparam logic [DIM_W-1:0] RST_COLS = DIM_W'(32);
	localparam logic [LEN_W-1:0] RST_WLEN = LEN_W'(1000);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WLEN = CFG_IDX_W'(2);

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	typedef enum logic [1:0] {
		CMD_SET,
		CMD_CLOSE,
		CMD_FLUSH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} cmd_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_PREP,
		FE_DIV,
		FE_DONE
	} fe_state_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} bk_state_t;

endpackage

/* rtl/evof_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Window tracker: classifies each item against the open window and realigns
// the window start when a window closes, through a bit-serial remainder unit if the item is late.
module evof_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [evof_pkg::TS_W-1:0]        timestamp,
	input  logic [evof_pkg::PIX_W-1:0]       pixel_x,
	input  logic [evof_pkg::PIX_W-1:0]       pixel_y,
	input  logic [evof_pkg::LEN_W-1:0]       window_length,
	output logic                             push,
	output evof_pkg::cmd_t                   push_cmd,
	input  logic                             q_full
);

	localparam int TS_W  = evof_pkg::TS_W;
	localparam int LEN_W = evof_pkg::LEN_W;
	localparam int NS_W  = TS_W + 1;
	localparam int CNT_W = $clog2(TS_W);

	evof_pkg::fe_state_t state_q, state_nx;

	logic [TS_W-1:0]  ws_q;
	logic             opened_q;
	logic [TS_W-1:0]  ts_q;
	logic [NS_W-1:0]  ns_q;
	logic [LEN_W-1:0] len_q;
	logic [TS_W-1:0]  dvd_q;
	logic [LEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;

	logic [LEN_W-1:0] eff_len;
	logic [NS_W-1:0]  ws_end;
	logic             in_win;
	logic             accept;
	logic             busy;
	logic             late;
	logic [LEN_W:0]   rem_sh;
	logic             rem_ge;
	logic [LEN_W-1:0] rem_nx;
	logic             last_step;

	// Window end and classification
	always_comb begin
		eff_len = (window_length == '0) ? LEN_W'(1) : window_length;
		ws_end  = {1'b0, ws_q} + NS_W'(eff_len);
		in_win  = !opened_q || ((timestamp >= ws_q) && ({1'b0, timestamp} < ws_end));
	end

	// Restoring remainder step, one dividend bit a cycle
	always_comb begin
		late      = {1'b0, ts_q} >= ns_q;
		rem_sh    = {rem_q, dvd_q[TS_W-1]};
		rem_ge    = rem_sh >= {1'b0, len_q};
		rem_nx    = rem_ge ? LEN_W'(rem_sh - {1'b0, len_q}) : rem_sh[LEN_W-1:0];
		last_step = cnt_q == CNT_W'(TS_W - 1);
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			evof_pkg::FE_IDLE: begin
				if (accept && !func && !in_win) state_nx = evof_pkg::FE_PREP;
			end
			evof_pkg::FE_PREP: begin
				state_nx = late ? evof_pkg::FE_DIV : evof_pkg::FE_IDLE;
			end
			evof_pkg::FE_DIV: begin
				if (last_step) state_nx = evof_pkg::FE_DONE;
			end
			evof_pkg::FE_DONE: begin
				state_nx = evof_pkg::FE_IDLE;
			end
			default: begin
				state_nx = evof_pkg::FE_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		busy        = state_q != evof_pkg::FE_IDLE;
		in_stall    = busy || q_full;
		accept      = in_valid && !in_stall;
		push        = accept;
		push_cmd.x  = pixel_x;
		push_cmd.y  = pixel_y;
		if (func) push_cmd.op = evof_pkg::CMD_FLUSH;
		else if (in_win) push_cmd.op = evof_pkg::CMD_SET;
		else push_cmd.op = evof_pkg::CMD_CLOSE;
	end

	// Window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= evof_pkg::FE_IDLE;
			ws_q     <= '0;
			opened_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				evof_pkg::FE_IDLE: begin
					if (accept) begin
						if (func) begin
							opened_q <= 1'b0;
						end else if (!opened_q) begin
							ws_q     <= timestamp;
							opened_q <= 1'b1;
						end
					end
				end
				evof_pkg::FE_PREP: begin
					cnt_q <= '0;
					if (!late) ws_q <= ns_q[TS_W-1:0];
				end
				evof_pkg::FE_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				evof_pkg::FE_DONE: begin
					ws_q <= ts_q - TS_W'(rem_q);
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// Divide datapath
	always_ff @(posedge clk) begin
		if (state_q == evof_pkg::FE_IDLE) begin
			ts_q  <= timestamp;
			ns_q  <= ws_end;
			len_q <= eff_len;
		end
		if (state_q == evof_pkg::FE_PREP) begin
			dvd_q <= ts_q - ns_q[TS_W-1:0];
			rem_q <= '0;
		end else if (state_q == evof_pkg::FE_DIV) begin
			dvd_q <= {dvd_q[TS_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	`ASSERT_PROP(a_div_ends, clk, arst_n, (state_q == evof_pkg::FE_DIV && last_step) |=> (state_q == evof_pkg::FE_DONE), "divide did not finish after the last step")

endmodule

/* rtl/evof_cmd_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Short command queue between the window tracker and the frame engine
module evof_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  evof_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output evof_pkg::cmd_t head_cmd,
	output logic           empty
);

	localparam int AW    = evof_pkg::CMDQ_AW;
	localparam int DEPTH = evof_pkg::CMDQ_DEPTH;

	evof_pkg::cmd_t entry_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;

	assign full     = count_q == (AW + 1)'(DEPTH);
	assign empty    = count_q == '0;
	assign head_cmd = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) count_q <= count_q + (AW + 1)'(1);
			else if (pop && !push) count_q <= count_q - (AW + 1)'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "command pushed into a full queue")
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty, "command popped from an empty queue")

endmodule

/* rtl/evof_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Frame engine: keeps the occupancy bitmap, sets bits and reads frames out
// row by row through the output register.
module evof_back #(
	parameter int MAX_ROWS = evof_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = evof_pkg::DEF_MAX_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  evof_pkg::cmd_t                q_cmd,
	output logic                          pop,
	input  logic [evof_pkg::DIM_W-1:0]    rows_in_use,
	input  logic [evof_pkg::DIM_W-1:0]    cols_in_use,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [evof_pkg::IDX_W-1:0]    row_index,
	output logic [evof_pkg::ROW_W-1:0]    row_bits,
	output logic                          last_row
);

	localparam int DIM_W    = evof_pkg::DIM_W;
	localparam int PIX_W    = evof_pkg::PIX_W;
	localparam int ROWS_LIM = (MAX_ROWS < evof_pkg::HW_LIMIT) ? MAX_ROWS : evof_pkg::HW_LIMIT;
	localparam int COLS_LIM = (MAX_COLS < evof_pkg::HW_LIMIT) ? MAX_COLS : evof_pkg::HW_LIMIT;
	localparam int RW       = (ROWS_LIM > 1) ? $clog2(ROWS_LIM) : 1;

	evof_pkg::bk_state_t state_q, state_nx;

	logic [COLS_LIM-1:0] bitmap_q [ROWS_LIM];
	logic                nonempty_q;
	logic [RW-1:0]       row_cnt_q;
	logic                pend_rec_q;
	logic [PIX_W-1:0]    pend_x_q;
	logic [PIX_W-1:0]    pend_y_q;
	logic                out_valid_q;
	logic [evof_pkg::IDX_W-1:0] row_index_q;
	logic [evof_pkg::ROW_W-1:0] row_bits_q;
	logic                last_row_q;

	logic [DIM_W-1:0]    eff_rows;
	logic [DIM_W-1:0]    eff_cols;
	logic [COLS_LIM-1:0] col_mask;
	logic [COLS_LIM-1:0] col_hot;
	logic                start;
	logic                load;
	logic                last;
	logic                finish;
	logic                rec_en;
	logic                rec_ok;
	logic [PIX_W-1:0]    rec_x;
	logic [PIX_W-1:0]    rec_y;

	// Frame size clamped to 1..limit
	always_comb begin
		if (rows_in_use == '0) eff_rows = DIM_W'(1);
		else if (rows_in_use > DIM_W'(ROWS_LIM)) eff_rows = DIM_W'(ROWS_LIM);
		else eff_rows = rows_in_use;
		if (cols_in_use == '0) eff_cols = DIM_W'(1);
		else if (cols_in_use > DIM_W'(COLS_LIM)) eff_cols = DIM_W'(COLS_LIM);
		else eff_cols = cols_in_use;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			evof_pkg::BK_IDLE: begin
				if (start) state_nx = evof_pkg::BK_EMIT;
			end
			evof_pkg::BK_EMIT: begin
				if (finish) state_nx = evof_pkg::BK_IDLE;
			end
			default: begin
				state_nx = evof_pkg::BK_IDLE;
			end
		endcase
	end

	// Outputs and record selection
	always_comb begin
		pop    = (state_q == evof_pkg::BK_IDLE) && !q_empty;
		start  = pop && ((q_cmd.op == evof_pkg::CMD_CLOSE) ||
			((q_cmd.op == evof_pkg::CMD_FLUSH) && nonempty_q));
		load   = (state_q == evof_pkg::BK_EMIT) && (!out_valid_q || !out_stall);
		last   = (DIM_W'(row_cnt_q) + DIM_W'(1)) == eff_rows;
		finish = load && last;
		rec_en = 1'b0;
		rec_x  = q_cmd.x;
		rec_y  = q_cmd.y;
		if (pop && (q_cmd.op == evof_pkg::CMD_SET)) begin
			rec_en = 1'b1;
		end else if (finish && pend_rec_q) begin
			rec_en = 1'b1;
			rec_x  = pend_x_q;
			rec_y  = pend_y_q;
		end
		rec_ok = ({1'b0, rec_y} < eff_rows) && ({1'b0, rec_x} < eff_cols);
		for (int k = 0; k < COLS_LIM; k++) begin
			col_mask[k] = DIM_W'(k) < eff_cols;
			col_hot[k]  = rec_x == PIX_W'(k);
		end
	end

	// Bitmap: cleared when a frame finishes, the pending event lands in the fresh one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS_LIM; i++) bitmap_q[i] <= '0;
			nonempty_q <= 1'b0;
		end else begin
			for (int i = 0; i < ROWS_LIM; i++) begin
				if (finish) begin
					bitmap_q[i] <= (rec_en && rec_ok && rec_y == PIX_W'(i)) ? col_hot : '0;
				end else if (rec_en && rec_ok && rec_y == PIX_W'(i)) begin
					bitmap_q[i] <= bitmap_q[i] | col_hot;
				end
			end
			if (finish) nonempty_q <= rec_en;
			else if (rec_en) nonempty_q <= 1'b1;
		end
	end

	// Readout control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= evof_pkg::BK_IDLE;
			row_cnt_q   <= '0;
			pend_rec_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (start) begin
				row_cnt_q  <= '0;
				pend_rec_q <= q_cmd.op == evof_pkg::CMD_CLOSE;
			end else if (load) begin
				row_cnt_q <= last ? '0 : row_cnt_q + RW'(1);
			end
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Output register and pending event payload
	always_ff @(posedge clk) begin
		if (start) begin
			pend_x_q <= q_cmd.x;
			pend_y_q <= q_cmd.y;
		end
		if (load) begin
			row_index_q <= evof_pkg::IDX_W'(row_cnt_q);
			row_bits_q  <= evof_pkg::ROW_W'(bitmap_q[row_cnt_q] & col_mask);
			last_row_q  <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign row_bits  = row_bits_q;
	assign last_row  = last_row_q;

	`ASSERT_PROP(a_finish_idle, clk, arst_n, finish |=> (state_q == evof_pkg::BK_IDLE), "readout did not end after the last row")
	`ASSERT_PROP(a_set_marks, clk, arst_n, (pop && q_cmd.op == evof_pkg::CMD_SET) |=> nonempty_q, "recorded event left the frame empty")

endmodule

/* rtl/event_window_occupancy_framer_unit.sv */
`timescale 1ns / 1ps
// In-window events: one item per cycle while the command queue has room; the pixel bit is set
// when the frame engine pops the event. An event that closes a window stalls the input while
// the 48-step remainder unit in the window tracker realigns the window start if needed.
// A close or non-empty flush reads out rows_in_use rows (clamped), one a cycle unless stalled.
// Reset (arst_n low, asynchronous): empty bitmap, no open window, empty queue, no
// result pending; registers return to 32 rows, 32 columns, window length 1000.
module event_window_occupancy_framer_unit #(
	parameter int MAX_ROWS = evof_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = evof_pkg::DEF_MAX_COLS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [evof_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [evof_pkg::LEN_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [evof_pkg::TS_W-1:0]         timestamp,
	input  logic [evof_pkg::PIX_W-1:0]        pixel_x,
	input  logic [evof_pkg::PIX_W-1:0]        pixel_y,
	input  logic                              polarity,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [evof_pkg::IDX_W-1:0]        row_index,
	output logic [evof_pkg::ROW_W-1:0]        row_bits,
	output logic                              last_row
);

	logic [evof_pkg::DIM_W-1:0] rows_q;
	logic [evof_pkg::DIM_W-1:0] cols_q;
	logic [evof_pkg::LEN_W-1:0] wlen_q;

	logic           push;
	evof_pkg::cmd_t push_cmd;
	logic           q_full;
	logic           q_pop;
	evof_pkg::cmd_t q_head;
	logic           q_empty;

	// Configuration registers; polarity does not enter the frame
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= evof_pkg::RST_ROWS;
			cols_q <= evof_pkg::RST_COLS;
			wlen_q <= evof_pkg::RST_WLEN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				evof_pkg::REG_ROWS: rows_q <= cfg_data[evof_pkg::DIM_W-1:0];
				evof_pkg::REG_COLS: cols_q <= cfg_data[evof_pkg::DIM_W-1:0];
				evof_pkg::REG_WLEN: wlen_q <= cfg_data;
				default: begin
					rows_q <= rows_q;
				end
			endcase
		end
	end

	evof_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.timestamp     (timestamp),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.window_length (wlen_q),
		.push          (push),
		.push_cmd      (push_cmd),
		.q_full        (q_full)
	);

	evof_cmd_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (q_head),
		.empty    (q_empty)
	);

	evof_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (q_head),
		.pop         (q_pop),
		.rows_in_use (rows_q),
		.cols_in_use (cols_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_index   (row_index),
		.row_bits    (row_bits),
		.last_row    (last_row)
	);

endmodule

/* test/evof_tb_pkg.sv */
`timescale 1ns / 1ps

package evof_tb_pkg;

	// Item kinds on the func field
	localparam logic FUNC_EVENT = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

endpackage

/* test/evof_frame_checker.sv */
`timescale 1ns / 1ps

module evof_frame_checker
	import evof_pkg::*;
	import evof_tb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 func,
	input  logic [TS_W-1:0]      timestamp,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [IDX_W-1:0]     row_index,
	input  logic [ROW_W-1:0]     row_bits,
	input  logic                 last_row,
	output int                   mismatches,
	output int                   pending
);

	localparam int ROW_CAP = (DEF_MAX_ROWS < HW_LIMIT) ? DEF_MAX_ROWS : HW_LIMIT;
	localparam int COL_CAP = (DEF_MAX_COLS < HW_LIMIT) ? DEF_MAX_COLS : HW_LIMIT;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [ROW_W-1:0] bits;
		logic             last;
	} frame_row_t;

	// Rows predicted but not yet seen on the output
	frame_row_t rows_due[$];

	// Shadow of the framer state and registers
	logic [ROW_W-1:0] occupancy [HW_LIMIT];
	logic [TS_W-1:0]  win_start;
	logic             win_open;
	logic             frame_dirty;
	logic [DIM_W-1:0] rows_reg;
	logic [DIM_W-1:0] cols_reg;
	logic [LEN_W-1:0] wlen_reg;
	int               fail_count;

	function automatic int unsigned rows_eff();
		int unsigned r;
		r = rows_reg;
		if (r < 1) r = 1;
		if (r > ROW_CAP) r = ROW_CAP;
		return r;
	endfunction

	function automatic int unsigned cols_eff();
		int unsigned c;
		c = cols_reg;
		if (c < 1) c = 1;
		if (c > COL_CAP) c = COL_CAP;
		return c;
	endfunction

	// Queue every active row of the frame, then clear it
	task automatic readout_frame();
		int unsigned nrows;
		int unsigned ncols;
		int unsigned j;
		logic [ROW_W-1:0] mask;
		frame_row_t r;
		nrows = rows_eff();
		ncols = cols_eff();
		mask = (ncols >= ROW_W) ? '1 : ((ROW_W'(1) << ncols) - ROW_W'(1));
		for (j = 0; j < nrows; j++) begin
			r.idx = IDX_W'(j);
			r.bits = occupancy[j] & mask;
			r.last = (j + 1 == nrows);
			rows_due = {rows_due, r};
		end
		for (j = 0; j < HW_LIMIT; j++)
			occupancy[j] = '0;
		frame_dirty = 1'b0;
	endtask

	// Out-of-size pixels still make the frame non-empty
	task automatic mark_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		if (y < rows_eff() && x < cols_eff())
			occupancy[y][x] = 1'b1;
		frame_dirty = 1'b1;
	endtask

	task automatic advance_window(input logic f, input logic [TS_W-1:0] ts,
			input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		logic [63:0] len;
		logic [63:0] nxt;
		logic [63:0] t;
		len = (wlen_reg == '0) ? 64'd1 : 64'(wlen_reg);
		t = 64'(ts);
		if (f == FUNC_FLUSH) begin
			if (frame_dirty)
				readout_frame();
			win_open = 1'b0;
		end else begin
			if (!win_open) begin
				win_start = ts;
				win_open = 1'b1;
			end
			if (t >= 64'(win_start) && t < 64'(win_start) + len) begin
				mark_pixel(x, y);
			end else begin
				// late or early event: close, then skip whole lengths as needed
				readout_frame();
				nxt = 64'(win_start) + len;
				if (t >= nxt + len)
					nxt += ((t - nxt) / len) * len;
				win_start = nxt[TS_W-1:0];
				mark_pixel(x, y);
			end
		end
	endtask

	task automatic check_row();
		frame_row_t want;
		if (rows_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected row: idx %0d bits %h last %0b",
					row_index, row_bits, last_row);
		end else begin
			want = rows_due.pop_front();
			if (want.idx !== row_index || want.bits !== row_bits || want.last !== last_row) begin
				fail_count++;
				if (fail_count <= 10)
					$display("row mismatch: expected idx %0d bits %h last %0b, got idx %0d bits %h last %0b",
						want.idx, want.bits, want.last, row_index, row_bits, last_row);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HW_LIMIT; i++)
				occupancy[i] = '0;
			win_start = '0;
			win_open = 1'b0;
			frame_dirty = 1'b0;
			rows_reg = RST_ROWS;
			cols_reg = RST_COLS;
			wlen_reg = RST_WLEN;
			rows_due.delete();
			fail_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_row();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS: rows_reg = cfg_data[DIM_W-1:0];
					REG_COLS: cols_reg = cfg_data[DIM_W-1:0];
					REG_WLEN: wlen_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				advance_window(func, timestamp, pixel_x, pixel_y);
			mismatches <= fail_count;
			pending <= rows_due.size();
		end
	end

endmodule

/* test/tb_event_window_occupancy_framer_unit.sv */
`timescale 1ns / 1ps

module tb_event_window_occupancy_framer_unit;
	import evof_pkg::*;
	import evof_tb_pkg::*;

	localparam int LONG_HOLD  = 400;
	localparam int SETTLE     = 100;
	localparam int IDLE_LIMIT = 3000;
	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 26;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = FUNC_EVENT;
	logic [TS_W-1:0]      timestamp = '0;
	logic [PIX_W-1:0]     pixel_x = '0;
	logic [PIX_W-1:0]     pixel_y = '0;
	logic                 polarity = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [IDX_W-1:0]     row_index;
	logic [ROW_W-1:0]     row_bits;
	logic                 last_row;

	int          fails;
	int          pending;
	int          idle_cycles = 0;
	int          burst_left = 0;
	logic        hold_req = 1'b0;
	logic [63:0] cur_len = 64'd1000;
	int unsigned rows_hint = 32;
	int unsigned cols_hint = 32;

	always #6 clk = ~clk;

	event_window_occupancy_framer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.timestamp (timestamp),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.polarity  (polarity),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row_index (row_index),
		.row_bits  (row_bits),
		.last_row  (last_row)
	);

	evof_frame_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.timestamp  (timestamp),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_index  (row_index),
		.row_bits   (row_bits),
		.last_row   (last_row),
		.mismatches (fails),
		.pending    (pending)
	);

	// Watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: stall patterns in spans, plus one long hold-off on request
	initial begin : rx_stall
		int unsigned mode;
		int unsigned span;
		int unsigned k;
		logic held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				out_stall <= 1'b1;
				held = 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(4, 40);
				for (k = 0; k < span; k++) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= 1'($urandom_range(0, 1));
						default: out_stall <= (k % 3 != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Write all three registers in one held-valid sequence
	task automatic configure(input logic [LEN_W-1:0] rows_word,
			input logic [LEN_W-1:0] cols_word, input logic [LEN_W-1:0] len_word);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [LEN_W-1:0] val [3];
		int k;
		idx = '{REG_ROWS, REG_COLS, REG_WLEN};
		val = '{rows_word, cols_word, len_word};
		cfg_valid <= 1'b1;
		for (k = 0; k < 3; k++) begin
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_len = (len_word == '0) ? 64'd1 : 64'(len_word);
		rows_hint = (rows_word[DIM_W-1:0] == 0) ? 1 : rows_word[DIM_W-1:0];
		if (rows_hint > 32) rows_hint = 32;
		cols_hint = (cols_word[DIM_W-1:0] == 0) ? 1 : cols_word[DIM_W-1:0];
		if (cols_hint > 32) cols_hint = 32;
	endtask

	// One item; the sender idles between bursts of random length
	task automatic send(input logic f, input logic [TS_W-1:0] ts,
			input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y, input logic pol);
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		func <= f;
		timestamp <= ts;
		pixel_x <= x;
		pixel_y <= y;
		polarity <= pol;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
	endtask

	// Stop sending and wait until every predicted row has come out
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly advancing timestamps, with early, far and noise items mixed in
	task automatic random_phase(input int n_items);
		logic [TS_W-1:0] ts;
		logic [63:0] step;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic f;
		int unsigned pick;
		int i;
		ts = ($urandom_range(0, 1) == 0) ? TS_W'(rand64()) : TS_W'($urandom_range(0, 5000));
		for (i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			f = FUNC_EVENT;
			if (pick < 6) begin
				f = FUNC_FLUSH;
			end else if (pick < 11) begin
				ts = TS_W'(rand64());
			end else if (pick < 18) begin
				step = 64'd1 + rand64() % (2 * cur_len);
				ts = ts - TS_W'(step);
			end else if (pick < 70) begin
				step = rand64() % (cur_len / 4 + 1);
				ts = ts + TS_W'(step);
			end else if (pick < 90) begin
				step = 64'd1 + rand64() % (2 * cur_len);
				ts = ts + TS_W'(step);
			end else begin
				step = cur_len * $urandom_range(2, 9) + rand64() % cur_len;
				ts = ts + TS_W'(step);
			end
			x = ($urandom_range(0, 9) < 7) ? PIX_W'($urandom_range(0, cols_hint - 1))
				: PIX_W'($urandom);
			y = ($urandom_range(0, 9) < 7) ? PIX_W'($urandom_range(0, rows_hint - 1))
				: PIX_W'($urandom);
			send(f, ts, x, y, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : stimulus
		logic [LEN_W-1:0] rw;
		logic [LEN_W-1:0] cw;
		logic [LEN_W-1:0] lw;
		int ph;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: window edges, skipping, early event, flushes, wrap
		send(FUNC_EVENT, 48'd0, 5'd0, 5'd0, 1'b0);
		send(FUNC_EVENT, 48'd5, 5'd31, 5'd31, 1'b1);
		send(FUNC_EVENT, 48'd999, 5'd5, 5'd3, 1'b0);
		send(FUNC_EVENT, 48'd1000, 5'd1, 5'd1, 1'b1);
		send(FUNC_EVENT, 48'd8013, 5'd2, 5'd2, 1'b0);
		send(FUNC_EVENT, 48'd100, 5'd3, 5'd4, 1'b0);
		send(FUNC_FLUSH, 48'd100, 5'd0, 5'd0, 1'b0);
		send(FUNC_FLUSH, 48'd200, 5'd31, 5'd31, 1'b1);
		send(FUNC_EVENT, 48'hFFFF_FFFF_FFFF, 5'd31, 5'd0, 1'b1);
		send(FUNC_EVENT, 48'd0, 5'd0, 5'd31, 1'b0);
		send(FUNC_EVENT, 48'd500, 5'd7, 5'd9, 1'b0);
		send(FUNC_EVENT, 48'd2500, 5'd16, 5'd16, 1'b1);
		send(FUNC_FLUSH, 48'd2600, 5'd0, 5'd0, 1'b0);
		drain();

		// Small frame, zero length: out-of-size pixels, flush of a blank frame
		configure(LEN_W'(3), LEN_W'(5), LEN_W'(0));
		send(FUNC_EVENT, 48'd10, 5'd4, 5'd2, 1'b0);
		send(FUNC_EVENT, 48'd10, 5'd5, 5'd0, 1'b1);
		send(FUNC_EVENT, 48'd11, 5'd0, 5'd3, 1'b0);
		send(FUNC_FLUSH, 48'd11, 5'd0, 5'd0, 1'b0);
		drain();

		// Clamped sizes, longest window, start wrapping past the top
		configure(LEN_W'(0), LEN_W'(63), {LEN_W{1'b1}});
		send(FUNC_EVENT, 48'hFFFF_FFFF_FFFB, 5'd0, 5'd0, 1'b0);
		send(FUNC_EVENT, 48'h8000_0000_0000, 5'd31, 5'd0, 1'b1);
		send(FUNC_EVENT, 48'h0000_8000_0000, 5'd12, 5'd0, 1'b0);
		send(FUNC_FLUSH, 48'd0, 5'd0, 5'd0, 1'b0);
		drain();

		// Random phases, each under its own register settings
		for (ph = 0; ph < PHASES; ph++) begin
			rw = LEN_W'($urandom);
			cw = LEN_W'($urandom);
			case ($urandom_range(0, 2))
				0: lw = LEN_W'($urandom_range(1, 100));
				1: lw = LEN_W'($urandom_range(0, 5000));
				default: lw = LEN_W'($urandom);
			endcase
			case (ph)
				0: begin rw = LEN_W'(32); cw = LEN_W'(32); lw = {LEN_W{1'b1}}; end
				1: begin rw = LEN_W'(1); cw = LEN_W'(1); lw = LEN_W'(1); end
				2: begin rw = LEN_W'(32); cw = LEN_W'(32); lw = LEN_W'(20); end
				3: begin rw = LEN_W'(63); cw = LEN_W'(0); end
				default: ;
			endcase
			configure(rw, cw, lw);
			if (ph == 2) begin
				// Receiver holds off while the sender keeps pushing
				hold_req <= 1'b1;
				burst_left = 1000;
			end
			random_phase(PHASE_ITEMS);
			drain();
		end

		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/evof_pkg.sv
rtl/evof_front.sv
rtl/evof_cmd_fifo.sv
rtl/evof_back.sv
rtl/event_window_occupancy_framer_unit.sv
test/evof_tb_pkg.sv
test/evof_frame_checker.sv
test/tb_event_window_occupancy_framer_unit.sv
